@@ rtl/core/lgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    localparam int unsigned SURVIVE_COUNT = 2;
    localparam int unsigned BIRTH_COUNT   = 3;

    typedef struct packed {
        logic load;
        logic clear_grid;
        logic rd_item;
        logic rd_sweep;
        logic win_clear;
        logic win_shift;
        logic cnt_clr;
        logic cnt_inc;
        logic wr_cell;
        logic wr_gen;
        logic out_load;
    } lgs_cmd_t;

    typedef struct packed {
        action_t act;
        logic    row_ok;
        logic    col_ok;
        logic    sweep_rd;
        logic    sweep_wr;
        logic    sweep_end;
        logic    out_free;
    } lgs_status_t;

endpackage

@@ rtl/core/lgs_row_rule.sv @@
// ----------------------------------------------------------------------------
// lgs_row_rule
// Next generation of one row from the row above, the row itself and below.
// ----------------------------------------------------------------------------
module lgs_row_rule #(
    parameter int unsigned GRID_COLS = 32
) (
    input  logic [GRID_COLS-1:0] up_row,
    input  logic [GRID_COLS-1:0] mid_row,
    input  logic [GRID_COLS-1:0] down_row,
    output logic [GRID_COLS-1:0] next_row
);
    import lgs_pkg::*;

    logic [GRID_COLS+1:0] up_pad;
    logic [GRID_COLS+1:0] mid_pad;
    logic [GRID_COLS+1:0] down_pad;
    logic [3:0]           count [GRID_COLS];

    assign up_pad   = {1'b0, up_row, 1'b0};
    assign mid_pad  = {1'b0, mid_row, 1'b0};
    assign down_pad = {1'b0, down_row, 1'b0};

    always_comb
    begin
        for (int c = 0; c < GRID_COLS; c++)
        begin
            count[c] = 4'(up_pad[c]) + 4'(up_pad[c+1]) + 4'(up_pad[c+2])
                     + 4'(mid_pad[c]) + 4'(mid_pad[c+2])
                     + 4'(down_pad[c]) + 4'(down_pad[c+1]) + 4'(down_pad[c+2]);
            next_row[c] = (count[c] == 4'(BIRTH_COUNT))
                        || (mid_row[c] && (count[c] == 4'(SURVIVE_COUNT)));
        end
    end

endmodule

@@ rtl/core/lgs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lgs_ctrl
// Sequencer for the life block: decodes each word and drives the datapath.
// ----------------------------------------------------------------------------
module lgs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lgs_pkg::lgs_status_t status,
    output lgs_pkg::lgs_cmd_t    cmd
);
    import lgs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_MODIFY = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.act)
                    ACT_CLEAR:
                    begin
                        cmd.clear_grid = 1'b1;
                        state_next     = S_RESULT;
                    end
                    ACT_WRITE:
                    begin
                        if (status.row_ok && status.col_ok)
                        begin
                            cmd.rd_item = 1'b1;
                            state_next  = S_MODIFY;
                        end
                        else
                        begin
                            state_next = S_RESULT;
                        end
                    end
                    ACT_STEP:
                    begin
                        cmd.cnt_clr   = 1'b1;
                        cmd.win_clear = 1'b1;
                        state_next    = S_SWEEP;
                    end
                    ACT_READ:
                    begin
                        cmd.rd_item = status.row_ok;
                        state_next  = S_RESULT;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_MODIFY:
            begin
                cmd.wr_cell = 1'b1;
                state_next  = S_RESULT;
            end
            S_SWEEP:
            begin
                cmd.rd_sweep  = status.sweep_rd;
                cmd.wr_gen    = status.sweep_wr;
                cmd.win_shift = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (status.sweep_end)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/lgs_datapath.sv @@
// ----------------------------------------------------------------------------
// lgs_datapath
// Grid memory with row valid bits, three-row window, sweep counter and
// output register.
// ----------------------------------------------------------------------------
module lgs_datapath #(
    parameter int unsigned GRID_ROWS = 32,
    parameter int unsigned GRID_COLS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    input  lgs_pkg::lgs_cmd_t    cmd,
    output lgs_pkg::lgs_status_t status
);
    import lgs_pkg::*;

    localparam int unsigned ADDR_W = $clog2(GRID_ROWS);
    localparam int unsigned CNT_W  = $clog2(GRID_ROWS + 2);

    logic [GRID_COLS-1:0] mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] valid_reg;

    action_t              act_reg;
    logic [4:0]           row_reg;
    logic [4:0]           col_reg;
    logic                 alive_reg;

    logic [CNT_W-1:0]     cnt_reg;
    logic [GRID_COLS-1:0] rd_data_reg;
    logic                 rd_hit_reg;
    logic [GRID_COLS-1:0] up_reg;
    logic [GRID_COLS-1:0] mid_reg;
    logic                 out_valid_reg;
    logic [31:0]          out_data_reg;
    logic [31:0]          out_data_next;

    logic [6:0]           row_ext;
    logic [6:0]           col_ext;
    logic                 row_ok;
    logic [ADDR_W-1:0]    item_addr;
    logic [CNT_W-1:0]     wr_cnt;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic [GRID_COLS-1:0] down_row;
    logic [GRID_COLS-1:0] gen_row;
    logic [GRID_COLS-1:0] cell_row;
    logic [GRID_COLS-1:0] wr_data;

    assign row_ext   = {2'b00, row_reg};
    assign col_ext   = {2'b00, col_reg};
    assign row_ok    = (row_ext < 7'(GRID_ROWS));
    assign item_addr = row_ext[ADDR_W-1:0];
    assign wr_cnt    = cnt_reg - CNT_W'(2);

    assign rd_en   = cmd.rd_item | cmd.rd_sweep;
    assign rd_addr = cmd.rd_sweep ? cnt_reg[ADDR_W-1:0] : item_addr;
    assign wr_en   = cmd.wr_cell | cmd.wr_gen;
    assign wr_addr = cmd.wr_gen ? wr_cnt[ADDR_W-1:0] : item_addr;
    assign wr_data = cmd.wr_gen ? gen_row : cell_row;

    assign down_row = rd_hit_reg ? rd_data_reg : '0;

    always_comb
    begin
        for (int c = 0; c < GRID_COLS; c++)
        begin
            cell_row[c] = (col_ext == 7'(c)) ? alive_reg : down_row[c];
        end
    end

    lgs_row_rule #(
        .GRID_COLS (GRID_COLS)
    ) u_rule (
        .up_row   (up_reg),
        .mid_row  (mid_reg),
        .down_row (down_row),
        .next_row (gen_row)
    );

    assign status.act       = act_reg;
    assign status.row_ok    = row_ok;
    assign status.col_ok    = (col_ext < 7'(GRID_COLS));
    assign status.sweep_rd  = (cnt_reg < CNT_W'(GRID_ROWS));
    assign status.sweep_wr  = (cnt_reg >= CNT_W'(2));
    assign status.sweep_end = (cnt_reg == CNT_W'(GRID_ROWS + 1));
    assign status.out_free  = !out_valid_reg || m_tready;

    generate
        for (genvar b = 0; b < 32; b++)
        begin : g_out
            if (b < GRID_COLS)
            begin : g_cell
                assign out_data_next[b] = (act_reg == ACT_READ) && row_ok && down_row[b];
            end
            else
            begin : g_pad
                assign out_data_next[b] = 1'b0;
            end
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_hit_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            act_reg       <= ACT_CLEAR;
        end
        else
        begin
            if (cmd.clear_grid)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end

            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
            else if (cmd.win_clear || cmd.win_shift)
            begin
                rd_hit_reg <= 1'b0;
            end

            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.load)
            begin
                act_reg <= action_t'(s_tuser);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg   <= s_tdata[4:0];
            col_reg   <= s_tdata[9:5];
            alive_reg <= s_tdata[10];
        end
        if (cmd.win_clear)
        begin
            up_reg  <= '0;
            mid_reg <= '0;
        end
        else if (cmd.win_shift)
        begin
            up_reg  <= mid_reg;
            mid_reg <= down_row;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ rtl/core/life_generation_step.sv @@
// ----------------------------------------------------------------------------
// life_generation_step
// Bounded grid of one-bit cells advanced by the B3/S23 rule, with commands
// to clear the grid, write a cell, advance one generation and read a row.
//
//   Channel  Direction  Signals                     Contents
//   s_*      in         tvalid tready tdata tuser   command word
//   m_*      out        tvalid tready tdata         result row word
//
// A clear or a read goes from accept through decode to the result, and a
// cell write inside the grid adds a modify step; a write outside the grid
// goes straight to the result. An advance sweeps the grid, reading one row
// per cycle through the single read port of the grid memory. One word is
// handled at a time; a new word is taken while the last result still waits.
// After reset the row valid bits are clear, so the grid reads as all dead
// at once, with no clearing pass.
// ----------------------------------------------------------------------------
module life_generation_step #(
    parameter int unsigned GRID_ROWS = 32,
    parameter int unsigned GRID_COLS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // row_index[4:0], col_index[9:5], alive[10], zero[15:11]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // row_bits[31:0]
);
    import lgs_pkg::*;

    lgs_cmd_t    cmd;
    lgs_status_t status;

    lgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lgs_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
